// ===== design/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// shared types and constants of the collinear point remover
// ----------------------------------------------------------------------------
package cpr_pkg;

   localparam int CoordBits = 24;
   localparam int DiffBits  = CoordBits + 1;
   localparam int TolBits   = 16;
   localparam int QueueDepth = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   localparam logic [TolBits-1:0] TolReset = 16'd256;

   localparam logic [1:0] PH_FIRST = 2'd0;
   localparam logic [1:0] PH_DIR   = 2'd1;
   localparam logic [1:0] PH_TRACK = 2'd2;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic signed [DiffBits-1:0]  diff_type;

   // one decoded item handed from the front to the back
   typedef struct packed {
      logic      emit_prev;
      logic      emit_cur;
      logic      cur_last;
      coord_type prev_x;
      coord_type prev_y;
      coord_type cur_x;
      coord_type cur_y;
   } job_type;

endpackage

// ===== design/cpr_front.sv =====
// ----------------------------------------------------------------------------
// cpr_front
// tracks anchor, direction and previous point; classifies each point
// ----------------------------------------------------------------------------
module cpr_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cpr_pkg::coord_type              req_point_x,
   input  cpr_pkg::coord_type              req_point_y,
   input  logic                            req_last_point,
   input  logic [cpr_pkg::TolBits-1:0]     tolerance,
   output logic                            job_valid,
   output cpr_pkg::job_type                job,
   input  logic                            job_full
);

   localparam int PW = 2 * cpr_pkg::DiffBits + 2;
   localparam int TW = cpr_pkg::TolBits + cpr_pkg::DiffBits;

   logic [1:0]           phase_ff, phase_in;
   cpr_pkg::coord_type   anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   cpr_pkg::coord_type   prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   cpr_pkg::diff_type    ref_dx_ff, ref_dx_in, ref_dy_ff, ref_dy_in;

   cpr_pkg::diff_type    ex, ey, adx;
   logic signed [PW-1:0] p, q, d, ad;
   logic [TW-1:0]        thr;
   logic [cpr_pkg::DiffBits-1:0] aex;
   logic                 brk, accept;

   assign req_stall = job_full;
   assign accept    = req_valid && !job_full;

   always_comb begin
      ex  = cpr_pkg::diff_type'(req_point_x) - cpr_pkg::diff_type'(anchor_x_ff);
      ey  = cpr_pkg::diff_type'(req_point_y) - cpr_pkg::diff_type'(anchor_y_ff);
      p   = PW'(ey) * PW'(ref_dx_ff);
      q   = PW'(ref_dy_ff) * PW'(ex);
      d   = p - q;
      ad  = d[PW-1] ? -d : d;
      adx = ref_dx_ff[cpr_pkg::DiffBits-1] ? -ref_dx_ff : ref_dx_ff;
      thr = TW'(tolerance) * TW'($unsigned(adx));
      aex = ex[cpr_pkg::DiffBits-1] ? $unsigned(-ex) : $unsigned(ex);
      if (ref_dx_ff == '0) begin
         brk = {8'd0, aex} >= (cpr_pkg::DiffBits + 8)'(tolerance);
      end else begin
         brk = $unsigned(ad) >= PW'(thr);
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      prev_x_in   = req_point_x;
      prev_y_in   = req_point_y;
      ref_dx_in   = ref_dx_ff;
      ref_dy_in   = ref_dy_ff;
      job.emit_prev = 1'b0;
      job.emit_cur  = 1'b0;
      job.cur_last  = req_last_point;
      job.prev_x    = prev_x_ff;
      job.prev_y    = prev_y_ff;
      job.cur_x     = req_point_x;
      job.cur_y     = req_point_y;
      unique case (phase_ff)
         cpr_pkg::PH_DIR: begin
            ref_dx_in    = ex;
            ref_dy_in    = ey;
            job.emit_cur = req_last_point;
            phase_in     = req_last_point ? cpr_pkg::PH_FIRST : cpr_pkg::PH_TRACK;
         end
         cpr_pkg::PH_TRACK: begin
            if (brk) begin
               job.emit_prev = 1'b1;
               anchor_x_in   = prev_x_ff;
               anchor_y_in   = prev_y_ff;
               ref_dx_in = cpr_pkg::diff_type'(req_point_x) - cpr_pkg::diff_type'(prev_x_ff);
               ref_dy_in = cpr_pkg::diff_type'(req_point_y) - cpr_pkg::diff_type'(prev_y_ff);
            end
            job.emit_cur = req_last_point;
            if (req_last_point) begin
               phase_in = cpr_pkg::PH_FIRST;
            end
         end
         default: begin
            anchor_x_in  = req_point_x;
            anchor_y_in  = req_point_y;
            job.emit_cur = 1'b1;
            phase_in     = req_last_point ? cpr_pkg::PH_FIRST : cpr_pkg::PH_DIR;
         end
      endcase
   end

   assign job_valid = accept && (job.emit_prev || job.emit_cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= cpr_pkg::PH_FIRST;
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
         ref_dx_ff   <= '0;
         ref_dy_ff   <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         anchor_x_ff <= anchor_x_in;
         anchor_y_ff <= anchor_y_in;
         prev_x_ff   <= prev_x_in;
         prev_y_ff   <= prev_y_in;
         ref_dx_ff   <= ref_dx_in;
         ref_dy_ff   <= ref_dy_in;
      end
   end

endmodule

// ===== design/cpr_back.sv =====
// ----------------------------------------------------------------------------
// cpr_back
// job queue and emitter: sends the previous and/or current point
// ----------------------------------------------------------------------------
module cpr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  cpr_pkg::job_type    job,
   output logic                job_full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cpr_pkg::coord_type  rsp_out_x,
   output cpr_pkg::coord_type  rsp_out_y,
   output logic                rsp_out_last
);

   localparam int PB = cpr_pkg::QueuePtrBits;

   cpr_pkg::job_type q_ff [cpr_pkg::QueueDepth];
   logic [PB-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PB:0]   cnt_ff, cnt_in;
   logic          sub_ff, sub_in;   // prev half of head already sent
   cpr_pkg::job_type head;
   logic          push, pop, send;

   assign head      = q_ff[rd_ff];
   assign job_full  = cnt_ff == (PB + 1)'(cpr_pkg::QueueDepth);
   assign push      = job_valid;
   assign rsp_valid = cnt_ff != '0;
   assign send      = rsp_valid && !rsp_stall;

   always_comb begin
      if (head.emit_prev && !sub_ff) begin
         rsp_out_x    = head.prev_x;
         rsp_out_y    = head.prev_y;
         rsp_out_last = 1'b0;
      end else begin
         rsp_out_x    = head.cur_x;
         rsp_out_y    = head.cur_y;
         rsp_out_last = head.cur_last;
      end
   end

   always_comb begin
      pop    = send && !(head.emit_prev && head.emit_cur && !sub_ff);
      sub_in = send ? !pop : sub_ff;
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PB + 1)'(push) - (PB + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
         sub_ff <= 1'b0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
         sub_ff <= sub_in;
      end
   end

endmodule

// ===== design/collinear_point_remover.sv =====
// ----------------------------------------------------------------------------
// collinear_point_remover
// drops path points that lie on the current line within a tolerance
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// req      | req_valid/req_stall | req_point_x, req_point_y, req_last_point
// rsp      | rsp_valid/rsp_stall | rsp_out_x, rsp_out_y, rsp_out_last
// csr      | apb                 | tolerance at 0x0
// one point is taken per cycle while req_stall is low; the front classifies it in that cycle
// a four-entry job queue feeds the output; a job with two results holds it
// for two transfers, so req_stall rises only when the queue is full
// reset clears the line state, the queue and sets tolerance to 256
// ----------------------------------------------------------------------------
module collinear_point_remover (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cpr_pkg::coord_type  req_point_x,
   input  cpr_pkg::coord_type  req_point_y,
   input  logic                req_last_point,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cpr_pkg::coord_type  rsp_out_x,
   output cpr_pkg::coord_type  rsp_out_y,
   output logic                rsp_out_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [1:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic [cpr_pkg::TolBits-1:0] tol_ff;
   logic              job_valid, job_full;
   cpr_pkg::job_type  job;

   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {16'd0, tol_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= cpr_pkg::TolReset;
      end else if (psel && penable && pwrite && paddr == 2'd0) begin
         tol_ff <= pwdata[cpr_pkg::TolBits-1:0];
      end
   end

   cpr_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_point_x, .req_point_y,
      .req_last_point, .tolerance(tol_ff), .job_valid, .job, .job_full
   );

   cpr_back u_back (
      .clock, .reset, .job_valid, .job, .job_full, .rsp_valid, .rsp_stall,
      .rsp_out_x, .rsp_out_y, .rsp_out_last
   );

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid) else $error("stall without pending results");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");

endmodule

// ===== sim/collinear_point_remover_tb.sv =====
// ----------------------------------------------------------------------------
// collinear_point_remover_tb
// random and directed paths with a line-thinning predictor and a result queue
// ----------------------------------------------------------------------------
module collinear_point_remover_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] TolAddr = 2'd0;
   localparam int CycleLimit = 400000;

   typedef struct {
      cpr_pkg::coord_type x;
      cpr_pkg::coord_type y;
      logic               last;
   } kept_point_type;

   class thinning_board;
      kept_point_type kept_q[$];
      logic [cpr_pkg::TolBits-1:0] tol;
      logic [1:0] ph;
      logic signed [63:0] ax, ay, dx, dy, px, py;
      int errors;

      function void clear();
         tol = cpr_pkg::TolReset;
         ph = cpr_pkg::PH_FIRST;
         ax = 0; ay = 0; dx = 0; dy = 0; px = 0; py = 0;
         errors = 0;
         kept_q.delete();
      endfunction

      function void keep(logic signed [63:0] x, logic signed [63:0] y, logic l);
         kept_point_type k;
         k.x = x[cpr_pkg::CoordBits-1:0];
         k.y = y[cpr_pkg::CoordBits-1:0];
         k.last = l;
         kept_q.push_back(k);
      endfunction

      function bit off_line(logic signed [63:0] x, logic signed [63:0] y);
         logic signed [63:0] ex, ey, adx;
         logic signed [127:0] dev;
         ex = x - ax;
         ey = y - ay;
         if (dx == 0) return ((ex < 0) ? -ex : ex) >= tol;
         dev = 128'(ey) * 128'(dx) - 128'(dy) * 128'(ex);
         if (dev < 0) dev = -dev;
         adx = (dx < 0) ? -dx : dx;
         return dev >= 128'(adx) * 128'({48'd0, tol});
      endfunction

      function void note_point(cpr_pkg::coord_type xi, cpr_pkg::coord_type yi, logic l);
         logic signed [63:0] x, y;
         x = xi;
         y = yi;
         if (ph == cpr_pkg::PH_DIR) begin
            dx = x - ax; dy = y - ay; px = x; py = y;
            if (l) begin
               keep(x, y, 1'b1); ph = cpr_pkg::PH_FIRST;
            end else ph = cpr_pkg::PH_TRACK;
         end else if (ph == cpr_pkg::PH_TRACK) begin
            if (off_line(x, y)) begin
               keep(px, py, 1'b0);
               ax = px; ay = py; dx = x - px; dy = y - py;
            end
            px = x; py = y;
            if (l) begin
               keep(x, y, 1'b1); ph = cpr_pkg::PH_FIRST;
            end
         end else begin
            ax = x; ay = y; px = x; py = y;
            keep(x, y, l);
            ph = l ? cpr_pkg::PH_FIRST : cpr_pkg::PH_DIR;
         end
      endfunction

      function void check_point(cpr_pkg::coord_type x, cpr_pkg::coord_type y, logic l);
         kept_point_type k;
         if (kept_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer x=%0d y=%0d last=%0b", x, y, l);
            return;
         end
         k = kept_q.pop_front();
         if (k.x !== x || k.y !== y || k.last !== l) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                        k.x, k.y, k.last, x, y, l);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, req_last_point = 0;
   cpr_pkg::coord_type req_point_x = '0, req_point_y = '0;
   logic rsp_valid, rsp_stall = 0, rsp_out_last;
   cpr_pkg::coord_type rsp_out_x, rsp_out_y;
   logic psel = 0, penable = 0, pwrite = 0, pready;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0, prdata;

   thinning_board board = new();
   int cycles = 0;
   int idle_pct = 38;
   int hold_cycles = 0;
   bit hold_req = 0;

   collinear_point_remover uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) board.check_point(rsp_out_x, rsp_out_y, rsp_out_last);
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_req && hold_cycles == 0) hold_cycles = 300;
      if (hold_cycles > 0) begin
         hold_cycles--;
         if (hold_cycles == 0) hold_req = 0;
         rsp_stall <= 1;
      end else rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   task automatic write_tol(logic [cpr_pkg::TolBits-1:0] v);
      @(negedge clock);
      psel <= 1; pwrite <= 1; paddr <= TolAddr; pwdata <= {16'd0, v};
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.tol = v;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   // valid stays high between back-to-back transfers and drops only on idling
   task automatic send_point(cpr_pkg::coord_type x, cpr_pkg::coord_type y, logic l);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_point_x <= x; req_point_y <= y; req_last_point <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_point(x, y, l);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.kept_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic cpr_pkg::coord_type rand_coord();
      case ($urandom_range(3))
         0: return cpr_pkg::coord_type'($urandom);
         1: return cpr_pkg::coord_type'($signed($urandom_range(4000)) - 2000);
         2: return $urandom_range(1) ? cpr_pkg::coord_type'(24'h7fffff)
                                     : cpr_pkg::coord_type'(24'h800000);
         default: return cpr_pkg::coord_type'($signed($urandom_range(200000)) - 100000);
      endcase
   endfunction

   // path along a rough line with jitter, direction changes and stray points so breaks happen sometimes
   task automatic send_path(int len);
      int sx, sy, stx, sty, jit;
      sx = $signed($urandom_range(400000)) - 200000;
      sy = $signed($urandom_range(400000)) - 200000;
      stx = $signed($urandom_range(4000)) - 2000;
      sty = $urandom_range(3) == 0 ? 0 : $signed($urandom_range(4000)) - 2000;
      if ($urandom_range(4) == 0) stx = 0;
      for (int i = 0; i < len; i++) begin
         jit = $urandom_range(2) == 0 ? $signed($urandom_range(1200)) - 600 : 0;
         if ($urandom_range(9) == 0) begin
            stx = $signed($urandom_range(4000)) - 2000;
            sty = $signed($urandom_range(4000)) - 2000;
         end
         sx += stx;
         sy += sty;
         if ($urandom_range(19) == 0)
            send_point(rand_coord(), rand_coord(), i == len - 1);
         else
            send_point(cpr_pkg::coord_type'(sx + jit), cpr_pkg::coord_type'(sy - jit),
                       i == len - 1);
      end
   endtask

   initial begin
      int sent;
      board.clear();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: single point, two points, extremes, vertical and degenerate
      send_point(24'sh7fffff, 24'sh800000, 1'b1);
      send_point(24'sh800000, 24'sh7fffff, 1'b0);
      send_point(24'sh7fffff, 24'sh800000, 1'b1);
      send_point(24'sd0, 24'sd0, 1'b0);
      send_point(24'sd0, 24'sd0, 1'b0);
      send_point(24'sd255, 24'sd1000, 1'b0);
      send_point(24'sd256, 24'sd2000, 1'b1);
      send_point(24'sd0, 24'sd0, 1'b0);
      send_point(24'sd1000, 24'sd1000, 1'b0);
      send_point(24'sd2000, 24'sd2000, 1'b0);
      send_point(24'sd3000, 24'sd5000, 1'b0);
      send_point(24'sh7fffff, 24'sh7fffff, 1'b0);
      send_point(24'sh800000, 24'sh800000, 1'b1);
      drain();
      write_tol(16'd0);
      send_point(24'sd10, 24'sd10, 1'b0);
      send_point(24'sd20, 24'sd20, 1'b0);
      send_point(24'sd30, 24'sd30, 1'b0);
      send_point(24'sd40, 24'sd41, 1'b1);
      drain();
      write_tol(16'hffff);
      send_path(8);
      drain();
      write_tol(16'd256);

      sent = 0;
      while (sent < 1880) begin
         int len;
         if (sent > 300 && sent < 700) idle_pct = 0;
         else idle_pct = 38;
         if (sent > 900 && sent < 960 && !hold_req) hold_req = 1;
         if (sent % 400 < 10 && sent > 0) begin
            drain();
            write_tol(16'($urandom_range(3) == 0 ? $urandom_range(65535)
                                                 : $urandom_range(1500)));
         end
         len = $urandom_range(4) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 40);
         send_path(len);
         sent += len;
      end
      idle_pct = 38;
      drain();
      if (board.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
